// ===== sv/hisl_pkg.sv =====
// Shared commands, status codes and hash constants for the hashed id set.
package hisl_pkg;

   typedef logic [1:0] command_type;
   typedef logic [2:0] status_type;
   typedef logic [7:0] count_type;

   localparam command_type CMD_CLEAR  = 2'd0;
   localparam command_type CMD_INSERT = 2'd1;
   localparam command_type CMD_LOOKUP = 2'd2;

   localparam status_type ST_DONE     = 3'd0;
   localparam status_type ST_INSERTED = 3'd1;
   localparam status_type ST_PRESENT  = 3'd2;
   localparam status_type ST_FULL     = 3'd3;
   localparam status_type ST_ZERO_ID  = 3'd4;

   localparam logic [63:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam logic [5:0]  MIX_SHIFT_A = 6'd30;
   localparam logic [5:0]  MIX_SHIFT_B = 6'd27;
   localparam logic [5:0]  MIX_SHIFT_C = 6'd31;

endpackage

// ===== sv/hisl_hash.sv =====
// Iterative 64-bit mixer with one shared 32x32 multiplier, reduced to a home slot.
module hisl_hash #(
   parameter int SLOT_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   key,
   output logic                          done,
   output logic [$clog2(SLOT_COUNT)-1:0] home
);
   import hisl_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
   // floor(2^32 / SLOT_COUNT): the quotient estimate it gives is at most one low
   localparam logic [31:0] MOD_RECIP = 32'((64'd1 << 32) / 64'(SLOT_COUNT));
   localparam logic [31:0] MOD_DIV   = 32'(SLOT_COUNT);

   localparam logic [2:0] H_IDLE = 3'd0;
   localparam logic [2:0] H_XOR  = 3'd1;
   localparam logic [2:0] H_MUL  = 3'd2;
   localparam logic [2:0] H_FIN  = 3'd3;
   localparam logic [2:0] H_MOD  = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       round_ff, round_in;
   logic [1:0]       step_ff, step_in;
   logic [63:0]      z_ff, z_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      prod_ff, prod_in;
   logic [IDX_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;
   logic [IDX_W-1:0] home_ff, home_in;

   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_c;
   logic [5:0]     shamt;
   logic [63:0]    mixed;
   logic [31:0]    mod_x, mod_r0, mod_r;

   always_comb begin
      // next remainder digit: previous remainder followed by the top 16 hash bits
      mod_x  = (32'(rem_ff) << 16) | {16'd0, z_ff[63:48]};
      mod_r0 = mod_x - prod_ff[31:0];
      mod_r  = (mod_r0 >= MOD_DIV) ? mod_r0 - MOD_DIV : mod_r0;
      mul_c = (round_ff == 2'd0) ? MIX_MUL_A : MIX_MUL_B;
      if (state_ff == H_MOD) begin
         mul_a = (step_ff == 2'd0) ? mod_x : prod_ff[63:32];
         mul_b = (step_ff == 2'd0) ? MOD_RECIP : MOD_DIV;
      end else begin
         mul_a = (step_ff == 2'd1) ? z_ff[63:32] : z_ff[31:0];
         mul_b = (step_ff == 2'd2) ? mul_c[63:32] : mul_c[31:0];
      end
      case (round_ff)
         2'd0:    shamt = MIX_SHIFT_A;
         2'd1:    shamt = MIX_SHIFT_B;
         default: shamt = MIX_SHIFT_C;
      endcase
      mixed = z_ff ^ (z_ff >> shamt);
   end

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      step_in  = step_ff;
      z_in     = z_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      home_in  = home_ff;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               z_in     = {{32{key[31]}}, key} + MIX_ADD;
               round_in = 2'd0;
               state_in = H_XOR;
            end
         end
         H_XOR: begin
            z_in = mixed;
            if (round_ff == 2'd2) begin
               state_in = H_FIN;
            end else begin
               step_in  = 2'd0;
               state_in = H_MUL;
            end
         end
         H_MUL: begin
            // low 64 bits of the product: lo*lo, then the two cross terms into the high half
            prod_in = 64'(mul_a) * 64'(mul_b);
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd1:    acc_in = prod_ff;
               2'd2:    acc_in = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
               2'd3: begin
                  z_in     = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
                  round_in = round_ff + 2'd1;
                  state_in = H_XOR;
               end
               default: acc_in = acc_ff;
            endcase
         end
         H_FIN: begin
            if (IS_POW2) begin
               home_in  = z_ff[IDX_W-1:0];
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               rem_in   = '0;
               round_in = 2'd0;
               step_in  = 2'd0;
               state_in = H_MOD;
            end
         end
         H_MOD: begin
            // one 16-bit digit per round: estimate the quotient, multiply back, correct
            prod_in = 64'(mul_a) * 64'(mul_b);
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               rem_in   = mod_r[IDX_W-1:0];
               z_in     = z_ff << 16;
               step_in  = 2'd0;
               round_in = round_ff + 2'd1;
               if (round_ff == 2'd3) begin
                  home_in  = mod_r[IDX_W-1:0];
                  done_in  = 1'b1;
                  state_in = H_IDLE;
               end
            end
         end
         default: state_in = H_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      round_ff <= round_in;
      step_ff  <= step_in;
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      home_ff  <= home_in;
   end

   assign done = done_ff;
   assign home = home_ff;

endmodule

// ===== sv/hashed_id_set_linear_probe.sv =====
// Top level of the hashed id set: slot memory, probe sequencer and response register.
//
//  channel  direction  handshake                payload
//  req      in         req_valid / req_ready    req_command, req_id
//  rsp      out        rsp_valid / rsp_ready    rsp_status, rsp_found, rsp_count
//
// Reset starts a clearing sweep over all SLOT_COUNT slots, one slot a cycle; req_ready is low
// until it ends. A clear command runs the same sweep, then answers.
// Insert and lookup of a nonzero id: the hash unit runs two 64-bit multiplies on one 32x32
// multiplier, plus a remainder reduction when SLOT_COUNT is not a power of two; then the memory
// read port probes one slot per cycle, and the result is registered as the response word.
// A pending response word stalls the next result, not the next accept.
module hashed_id_set_linear_probe #(
   parameter int SLOT_COUNT    = 256,
   parameter int ELEMENT_LIMIT = 192
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  hisl_pkg::command_type    req_command,
   input  logic signed [31:0]       req_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output hisl_pkg::status_type     rsp_status,
   output logic                     rsp_found,
   output hisl_pkg::count_type      rsp_count
);
   import hisl_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(ELEMENT_LIMIT + 1);

   localparam logic [2:0] T_SWEEP = 3'd0;
   localparam logic [2:0] T_IDLE  = 3'd1;
   localparam logic [2:0] T_HASH  = 3'd2;
   localparam logic [2:0] T_CHK   = 3'd3;
   localparam logic [2:0] T_RESP  = 3'd4;

   logic [2:0]       state_ff, state_in;
   command_type      cmd_ff, cmd_in;
   logic [31:0]      key_ff, key_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             clr_reply_ff, clr_reply_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       res_status_ff, res_status_in;
   logic             res_found_ff, res_found_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic             rsp_found_ff, rsp_found_in;
   count_type        rsp_count_ff, rsp_count_in;
   logic [31:0]      rd_data_ff;

   logic [31:0] slot_mem [SLOT_COUNT];

   logic             accept;
   logic             hash_start, hash_done;
   logic [IDX_W-1:0] hash_home;
   logic [IDX_W-1:0] next_pos, rd_addr, wr_addr;
   logic             wr_en;
   logic [31:0]      wr_data;
   logic             slot_empty, slot_hit, last_probe, at_limit, out_free;
   logic [CNT_W+7:0] count_wide;

   hisl_hash #(
      .SLOT_COUNT(SLOT_COUNT)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (key_in),
      .done  (hash_done),
      .home  (hash_home)
   );

   assign req_ready  = (state_ff == T_IDLE);
   assign accept     = req_valid && req_ready;
   assign next_pos   = (pos_ff == IDX_W'(SLOT_COUNT - 1)) ? '0 : pos_ff + 1'b1;
   assign slot_empty = (rd_data_ff == 32'd0);
   assign slot_hit   = (rd_data_ff == key_ff);
   assign last_probe = (n_ff == IDX_W'(SLOT_COUNT - 1));
   assign at_limit   = (count_ff >= CNT_W'(ELEMENT_LIMIT));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_wide = (CNT_W+8)'(count_ff);
   // read the home slot as the hash lands, then run one slot ahead while probing
   assign rd_addr    = (state_ff == T_CHK) ? next_pos : hash_home;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      sweep_in      = sweep_ff;
      clr_reply_in  = clr_reply_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      hash_start    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = key_ff;
      case (state_ff)
         T_SWEEP: begin
            // empty one slot per cycle
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = 32'd0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == IDX_W'(SLOT_COUNT - 1)) begin
               state_in = clr_reply_ff ? T_RESP : T_IDLE;
            end
         end
         T_IDLE: begin
            if (accept) begin
               cmd_in        = req_command;
               key_in        = req_id;
               res_status_in = ST_DONE;
               res_found_in  = 1'b0;
               if (req_command == CMD_CLEAR) begin
                  sweep_in     = '0;
                  clr_reply_in = 1'b1;
                  count_in     = '0;
                  state_in     = T_SWEEP;
               end else if (req_command == CMD_INSERT && req_id == 32'sd0) begin
                  res_status_in = ST_ZERO_ID;
                  state_in      = T_RESP;
               end else if ((req_command == CMD_INSERT || req_command == CMD_LOOKUP) &&
                            req_id != 32'sd0) begin
                  hash_start = 1'b1;
                  state_in   = T_HASH;
               end else begin
                  // lookup of zero, unused command: answer at once
                  state_in = T_RESP;
               end
            end
         end
         T_HASH: begin
            if (hash_done) begin
               pos_in   = hash_home;
               n_in     = '0;
               state_in = T_CHK;
            end
         end
         T_CHK: begin
            if (slot_empty) begin
               if (cmd_ff == CMD_INSERT && !at_limit) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = ST_INSERTED;
                  res_found_in  = 1'b1;
               end else if (cmd_ff == CMD_INSERT) begin
                  res_status_in = ST_FULL;
               end
               state_in = T_RESP;
            end else if (slot_hit) begin
               res_found_in = 1'b1;
               if (cmd_ff == CMD_INSERT) begin
                  res_status_in = at_limit ? ST_FULL : ST_PRESENT;
               end
               state_in = T_RESP;
            end else if (last_probe) begin
               // every slot visited, neither the id nor a hole
               if (cmd_ff == CMD_INSERT) begin
                  res_status_in = ST_FULL;
               end
               state_in = T_RESP;
            end else begin
               pos_in = next_pos;
               n_in   = n_ff + 1'b1;
            end
         end
         T_RESP: begin
            // hold until the output word is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_found_in  = res_found_ff;
               rsp_count_in  = count_wide[7:0];
               clr_reply_in  = 1'b0;
               state_in      = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_SWEEP;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ELEMENT_LIMIT))
      else $error("entry count beyond element limit");

   a_hash_owner: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == T_HASH)
      else $error("hash result arrived outside the hash wait");

   a_write_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_CHK && wr_en) |-> (rd_data_ff == 32'd0 && key_ff != 32'd0))
      else $error("insert overwrote an occupied slot");

   a_clear_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_CLEAR) |=> (state_ff == T_SWEEP && count_ff == '0))
      else $error("clear did not start a sweep");

endmodule
